// ===== hdl/pid_controller_step_defines.svh =====
// Assertion macros for the PID step block.
`ifndef PID_CONTROLLER_STEP_DEFINES_SVH
`define PID_CONTROLLER_STEP_DEFINES_SVH

// same-cycle implication, off during reset
`define PIDC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PIDC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pidc_pkg.sv =====
// Shared types, constants and saturation helpers of the PID step block.
package pidc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIM_W     = 31;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MUL_A_W   = 33;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned ACC_W     = 66;
  localparam int unsigned FRAC_W    = 16;

  localparam logic [DATA_W-1:0] DEADBAND           = 32'd0;
  localparam logic [16:0]       SLOPE_FILTER_ALPHA = 17'd0;

  localparam int unsigned FLAG_INCREMENTAL = 0;
  localparam int unsigned FLAG_DERIV_MEAS  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN          = 3'd0,
    REG_INT_GAIN_DT        = 3'd1,
    REG_DERIV_GAIN_OVER_DT = 3'd2,
    REG_RAMP_STEP          = 3'd3,
    REG_INTEGRAL_BAND      = 3'd4,
    REG_INTEGRAL_CLAMP     = 3'd5,
    REG_OUTPUT_CLAMP       = 3'd6,
    REG_CONTROL_FLAGS      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] int_gain_dt;
    logic signed [DATA_W-1:0] deriv_gain_over_dt;
    logic [LIM_W-1:0]         ramp_step;
    logic [LIM_W-1:0]         integral_band;
    logic [LIM_W-1:0]         integral_clamp;
    logic [LIM_W-1:0]         output_clamp;
    logic [1:0]               control_flags;
  } pidc_cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] feedback;
  } pidc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] ramped_setpoint;
  } pidc_out_t;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || (~|top)) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                         input logic [LIM_W-1:0] lim);
    logic signed [ACC_W-1:0] pos;
    logic signed [ACC_W-1:0] neg;
    pos = signed'(ACC_W'(lim));
    neg = -pos;
    if (v > pos) begin
      return pos[DATA_W-1:0];
    end else if (v < neg) begin
      return neg[DATA_W-1:0];
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/pidc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
interface pidc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/pid_controller_step.sv =====
// PID controller step, Q16.16: sequencer around one shared multiplier.
// Sequence: ramp, error, optional slope filtering (nonzero alpha), integral term (skipped
// when |error| is outside the integral band), P and D products, sum. A new item is taken
// only in idle, once the previous result is registered;
// a result still held at the sum step stalls the sequencer until it is taken.
// Synchronous active-high reset clears the controller state and restores register defaults.
`include "pid_controller_step_defines.svh"

module pid_controller_step #(
  parameter logic [pidc_pkg::DATA_W-1:0] DEADBAND           = pidc_pkg::DEADBAND,
  parameter logic [16:0]                 SLOPE_FILTER_ALPHA = pidc_pkg::SLOPE_FILTER_ALPHA
) (
  input  logic                           clk,
  input  logic                           rst,
  pidc_stream_if.sink                    sample,
  pidc_stream_if.source                  command,
  input  logic                           cfg_write,
  input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]    cfg_data
);
  import pidc_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b00000000001,
    ST_RAMP      = 11'b00000000010,
    ST_ERR       = 11'b00000000100,
    ST_SLOPE     = 11'b00000001000,
    ST_FILT_WAIT = 11'b00000010000,
    ST_INT       = 11'b00000100000,
    ST_INT_WAIT  = 11'b00001000000,
    ST_P         = 11'b00010000000,
    ST_P_WAIT    = 11'b00100000000,
    ST_D_WAIT    = 11'b01000000000,
    ST_SUM       = 11'b10000000000
  } seq_state_t;

  localparam logic FILT_ON = (SLOPE_FILTER_ALPHA != '0);

  pidc_cfg_t  cfg;
  mul_req_t   mul_req;
  mul_stat_t  mul_st;
  seq_state_t state;

  logic signed [DATA_W-1:0] mul_res;
  logic signed [DATA_W-1:0] sp_q, fb_q;
  logic signed [DATA_W-1:0] ramp_value, integrator_sum, last_error, last_measurement;
  logic signed [DATA_W-1:0] last_filtered_slope, last_drive;
  logic signed [DATA_W-1:0] err_q, slope_q, inc_q, pterm, dterm;
  logic                     integ_on;
  pidc_out_t                out_q;
  logic                     out_valid;

  logic                     incr;
  logic                     in_fire;
  logic                     sum_go;
  logic signed [DATA_W-1:0] ramp_next, err_raw, err_next, raw_val, drive_next;
  logic [DATA_W:0]          err_raw_abs, err_q_abs;
  logic signed [ACC_W-1:0]  drive_sum;
  logic signed [DATA_W:0]   clamp_pos, clamp_neg, drive_s;
  logic                     mul_wait;
  logic                     drive_ok;

  pidc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidc_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .stat   (mul_st),
    .result (mul_res)
  );

  assign incr    = cfg.control_flags[FLAG_INCREMENTAL];
  assign in_fire = sample.valid && sample.ready;
  assign sum_go  = !out_valid || command.ready;

  assign sample.ready    = (state == ST_IDLE);
  assign command.valid   = out_valid;
  assign command.payload = out_q;

  always_comb begin
    if (cfg.ramp_step == '0) begin
      ramp_next = sp_q;
    end else begin
      ramp_next = ramp_value
                + clamp_sym(ACC_W'(sp_q) - ACC_W'(ramp_value), cfg.ramp_step);
    end

    err_raw     = sat32(ACC_W'(ramp_value) - ACC_W'(fb_q));
    err_raw_abs = err_raw[DATA_W-1] ? -((DATA_W+1)'(err_raw)) : (DATA_W+1)'(err_raw);
    err_next    = (err_raw_abs < (DATA_W+1)'(DEADBAND)) ? '0 : err_raw;
    err_q_abs   = err_q[DATA_W-1] ? -((DATA_W+1)'(err_q)) : (DATA_W+1)'(err_q);

    if (cfg.control_flags[FLAG_DERIV_MEAS]) begin
      raw_val = sat32(ACC_W'(last_measurement) - ACC_W'(fb_q));
    end else begin
      raw_val = sat32(ACC_W'(err_q) - ACC_W'(last_error));
    end

    if (incr) begin
      drive_sum = ACC_W'(last_drive) + ACC_W'(pterm) + ACC_W'(inc_q) + ACC_W'(dterm);
    end else begin
      drive_sum = ACC_W'(pterm) + ACC_W'(integrator_sum) + ACC_W'(dterm);
    end
    drive_next = clamp_sym(drive_sum, cfg.output_clamp);
  end

  always_comb begin
    mul_req = '0;
    unique case (state)
      ST_SLOPE: begin
        mul_req.start = FILT_ON;
        mul_req.a     = MUL_A_W'(raw_val) - MUL_A_W'(last_filtered_slope);
        mul_req.b     = MUL_B_W'(SLOPE_FILTER_ALPHA);
      end
      ST_INT: begin
        mul_req.start = integ_on;
        mul_req.a     = MUL_A_W'(err_q);
        mul_req.b     = MUL_B_W'(cfg.int_gain_dt);
      end
      ST_P: begin
        mul_req.start = 1'b1;
        mul_req.a     = incr ? MUL_A_W'(err_q) - MUL_A_W'(last_error) : MUL_A_W'(err_q);
        mul_req.b     = MUL_B_W'(cfg.prop_gain);
      end
      ST_P_WAIT: begin
        mul_req.start = mul_st.done;
        mul_req.a     = incr ? MUL_A_W'(slope_q) - MUL_A_W'(last_filtered_slope)
                             : MUL_A_W'(slope_q);
        mul_req.b     = cfg.deriv_gain_over_dt;
      end
      default: ;
    endcase
  end

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      ramp_value          <= '0;
      integrator_sum      <= '0;
      last_error          <= '0;
      last_measurement    <= '0;
      last_filtered_slope <= '0;
      last_drive          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_fire) state <= ST_RAMP;
        ST_RAMP: begin
          ramp_value <= ramp_next;
          state      <= ST_ERR;
        end
        ST_ERR: state <= ST_SLOPE;
        ST_SLOPE: state <= FILT_ON ? ST_FILT_WAIT : ST_INT;
        ST_FILT_WAIT: if (mul_st.done) state <= ST_INT;
        ST_INT: state <= integ_on ? ST_INT_WAIT : ST_P;
        ST_INT_WAIT: if (mul_st.done) begin
          integrator_sum <= clamp_sym(
              ACC_W'(sat32(ACC_W'(integrator_sum) + ACC_W'(mul_res))), cfg.integral_clamp);
          state <= ST_P;
        end
        ST_P: state <= ST_P_WAIT;
        ST_P_WAIT: if (mul_st.done) state <= ST_D_WAIT;
        ST_D_WAIT: if (mul_st.done) state <= ST_SUM;
        ST_SUM: if (sum_go) begin
          last_error          <= err_q;
          last_measurement    <= fb_q;
          last_filtered_slope <= slope_q;
          last_drive          <= drive_next;
          state               <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_fire) begin
        sp_q <= sample.payload.setpoint;
        fb_q <= sample.payload.feedback;
      end
      ST_ERR: err_q <= err_next;
      ST_SLOPE: begin
        integ_on <= (err_q_abs <= (DATA_W+1)'(cfg.integral_band));
        if (!FILT_ON) slope_q <= raw_val;
      end
      ST_FILT_WAIT: if (mul_st.done) begin
        slope_q <= sat32(ACC_W'(last_filtered_slope) + ACC_W'(mul_res));
      end
      ST_INT: if (!integ_on) inc_q <= '0;
      ST_INT_WAIT: if (mul_st.done) inc_q <= mul_res;
      ST_P_WAIT: if (mul_st.done) pterm <= mul_res;
      ST_D_WAIT: if (mul_st.done) dterm <= mul_res;
      ST_SUM: if (sum_go) begin
        out_q.drive           <= drive_next;
        out_q.ramped_setpoint <= ramp_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_SUM && sum_go) begin
      out_valid <= 1'b1;
    end else if (command.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign clamp_pos = signed'((DATA_W+1)'(cfg.output_clamp));
  assign clamp_neg = -clamp_pos;
  assign drive_s   = (DATA_W+1)'(out_q.drive);
  assign drive_ok  = (drive_s <= clamp_pos) && (drive_s >= clamp_neg);
  assign mul_wait  = (state == ST_FILT_WAIT) || (state == ST_INT_WAIT) ||
                     (state == ST_P_WAIT) || (state == ST_D_WAIT);

  `PIDC_ASSERT_NXT(a_accept_starts, clk, rst, in_fire, state == ST_RAMP, "sequence not started")
  `PIDC_ASSERT_IMP(a_mul_free, clk, rst, mul_req.start, !mul_st.busy, "multiplier started busy")
  `PIDC_ASSERT_IMP(a_mul_done_wait, clk, rst, mul_st.done, mul_wait, "result outside a wait")
  `PIDC_ASSERT_IMP(a_drive_clamped, clk, rst, out_valid, drive_ok, "drive outside output clamp")

endmodule

// ===== hdl/pidc_cfg.sv =====
// Configuration register file of the PID step block.
module pidc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]      cfg_data,
  output pidc_pkg::pidc_cfg_t              cfg
);
  import pidc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain          <= '0;
      cfg.int_gain_dt        <= '0;
      cfg.deriv_gain_over_dt <= '0;
      cfg.ramp_step          <= '0;
      cfg.integral_band      <= '1;
      cfg.integral_clamp     <= '1;
      cfg.output_clamp       <= '1;
      cfg.control_flags      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:          cfg.prop_gain          <= cfg_data[GAIN_W-1:0];
        REG_INT_GAIN_DT:        cfg.int_gain_dt        <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN_OVER_DT: cfg.deriv_gain_over_dt <= cfg_data;
        REG_RAMP_STEP:          cfg.ramp_step          <= cfg_data[LIM_W-1:0];
        REG_INTEGRAL_BAND:      cfg.integral_band      <= cfg_data[LIM_W-1:0];
        REG_INTEGRAL_CLAMP:     cfg.integral_clamp     <= cfg_data[LIM_W-1:0];
        REG_OUTPUT_CLAMP:       cfg.output_clamp       <= cfg_data[LIM_W-1:0];
        REG_CONTROL_FLAGS:      cfg.control_flags      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/pidc_mul.sv =====
// Shared two-pass multiplier with Q16.16 round-to-nearest and 32-bit saturation.
module pidc_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  pidc_pkg::mul_req_t                 req,
  output pidc_pkg::mul_stat_t                stat,
  output logic signed [pidc_pkg::DATA_W-1:0] result
);
  import pidc_pkg::*;

  localparam int unsigned HALF_W = MUL_B_W / 2;
  localparam int unsigned PP_W   = MUL_A_W + HALF_W + 1;
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_W - 1);

  typedef enum logic [3:0] {
    MP_IDLE = 4'b0001,
    MP_LO   = 4'b0010,
    MP_HI   = 4'b0100,
    MP_RND  = 4'b1000
  } mul_phase_t;

  mul_phase_t                phase;
  logic signed [MUL_A_W-1:0] a_q;
  logic signed [MUL_B_W-1:0] b_q;
  logic signed [ACC_W-1:0]   acc;
  logic                      done;
  logic signed [HALF_W:0]    b_part;
  logic signed [PP_W-1:0]    pp;
  logic signed [ACC_W-1:0]   pp_ext;
  logic signed [ACC_W-1:0]   rounded;

  always_comb begin
    if (phase == MP_LO) begin
      b_part = signed'({1'b0, b_q[HALF_W-1:0]});
    end else begin
      b_part = signed'({b_q[MUL_B_W-1], b_q[MUL_B_W-1:HALF_W]});
    end
    pp = PP_W'(a_q) * PP_W'(b_part);
    if (phase == MP_LO) begin
      pp_ext = ACC_W'(pp);
    end else begin
      pp_ext = ACC_W'(pp) <<< HALF_W;
    end
    rounded = (acc + HALF_LSB) >>> FRAC_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MP_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        MP_IDLE: if (req.start) phase <= MP_LO;
        MP_LO:   phase <= MP_HI;
        MP_HI:   phase <= MP_RND;
        MP_RND: begin
          phase <= MP_IDLE;
          done  <= 1'b1;
        end
        default: phase <= MP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      MP_IDLE: if (req.start) begin
        a_q <= req.a;
        b_q <= req.b;
      end
      MP_LO:   acc <= pp_ext;
      MP_HI:   acc <= acc + pp_ext;
      MP_RND:  result <= sat32(rounded);
      default: ;
    endcase
  end

  assign stat.busy = (phase != MP_IDLE);
  assign stat.done = done;

endmodule
